// ===== rtl/core/qvr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qvr_pkg
// Widths and constants shared by the quaternion vector rotator.
// ----------------------------------------------------------------------------
package qvr_pkg;

    localparam int QUAT_WIDTH      = 16;
    localparam int QUAT_FRAC_BITS  = 14;
    localparam int CFG_INDEX_WIDTH = 2;

    // quaternion products and the scaled rotation matrix
    localparam int PROD_WIDTH = 2 * QUAT_WIDTH;
    localparam int MAT_WIDTH  = PROD_WIDTH + 2;
    // divisor is twice the squared norm
    localparam int D_WIDTH    = MAT_WIDTH;

    typedef logic signed [QUAT_WIDTH-1:0] quat_t;

    // 1.0 in the quaternion format; zero when the fraction bits are not fewer than the width
    localparam quat_t QUAT_ONE = (QUAT_FRAC_BITS < QUAT_WIDTH) ?
                                 QUAT_WIDTH'(1 << QUAT_FRAC_BITS) : '0;

endpackage
`default_nettype wire

// ===== rtl/core/qvr_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qvr_div
// Three-lane pipelined restoring divider, one quotient bit per stage, with a
// valid/ready chain so a stall holds a stage only while every later stage is full.
// ----------------------------------------------------------------------------
module qvr_div
    import qvr_pkg::*;
#(
    parameter int VEC_WIDTH = 16
) (
    input  wire logic                                          aclk,
    input  wire logic                                          aresetn,
    input  wire logic                                          in_valid,
    output logic                                               in_ready,
    input  wire logic [2:0][D_WIDTH+VEC_WIDTH:0]               in_rem,
    input  wire logic [D_WIDTH-1:0]                            divisor,
    output logic                                               out_valid,
    input  wire logic                                          out_ready,
    output logic [2:0][VEC_WIDTH:0]                            out_quot
);

    localparam int QB = VEC_WIDTH + 1;
    localparam int RW = D_WIDTH + QB;

    logic [QB-1:0]                  vld_reg;
    logic [QB-1:0]                  vld_next;
    logic [QB:0]                    rdy;
    logic [2:0][RW-1:0]             rem_reg  [QB];
    logic [2:0][RW-1:0]             rem_next [QB];
    logic [2:0][QB-1:0]             quo_reg  [QB];
    logic [2:0][QB-1:0]             quo_next [QB];

    assign rdy[QB]   = out_ready;
    assign in_ready  = rdy[0];
    assign out_valid = vld_reg[QB-1];
    assign out_quot  = quo_reg[QB-1];

    for (genvar k = 0; k < QB; k++) begin : g_stage
        localparam int B = QB - 1 - k;

        logic               src_valid;
        logic [2:0][RW-1:0] src_rem;
        logic [2:0][QB-1:0] src_quo;
        logic [RW-1:0]      dsh;
        logic [RW:0]        trial [3];

        if (k == 0) begin : g_first
            assign src_valid = in_valid;
            assign src_rem   = in_rem;
            assign src_quo   = '0;
        end else begin : g_rest
            assign src_valid = vld_reg[k-1];
            assign src_rem   = rem_reg[k-1];
            assign src_quo   = quo_reg[k-1];
        end

        assign dsh    = RW'(divisor) << B;
        assign rdy[k] = !vld_reg[k] || rdy[k+1];

        always_comb begin
            vld_next[k] = src_valid;
            for (int l = 0; l < 3; l++) begin
                trial[l] = {1'b0, src_rem[l]} - {1'b0, dsh};
                // borrow out means the shifted divisor did not fit
                rem_next[k][l] = trial[l][RW] ? src_rem[l] : trial[l][RW-1:0];
                quo_next[k][l] = {src_quo[l][QB-2:0], ~trial[l][RW]};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (rdy[k]) begin
                vld_reg[k] <= vld_next[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (rdy[k] && src_valid) begin
                rem_reg[k] <= rem_next[k];
                quo_reg[k] <= quo_next[k];
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/quaternion_vector_rotate_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// quaternion_vector_rotate_top
// Rotates a stream of 3D vectors by a configured, not necessarily unit,
// quaternion with exact rounding and saturation.
// ----------------------------------------------------------------------------
// The block takes one vector word per cycle unless the output stalls, and
// returns one rotated word per vector, in order. Five front stages form the
// matrix-vector product and the biased dividend, a VEC_WIDTH + 1 stage
// restoring divider produces one quotient bit per stage, and a final stage
// removes the bias, saturates and holds the result word. The quaternion
// registers feed free-running product and matrix registers, so they are to be
// written only while no vector is in flight; the user must keep to this, as
// the block does not enforce it. A vector may follow the write on the next
// cycle. A zero quaternion yields a zero vector with the degenerate flag set.
module quaternion_vector_rotate_top
    import qvr_pkg::*;
#(
    parameter int VEC_WIDTH = 16
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        cfg_we,
    input  wire logic [CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  wire logic [QUAT_WIDTH-1:0]       cfg_wdata,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic signed [VEC_WIDTH-1:0] s_vec_in_x,
    input  wire logic signed [VEC_WIDTH-1:0] s_vec_in_y,
    input  wire logic signed [VEC_WIDTH-1:0] s_vec_in_z,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic signed [VEC_WIDTH-1:0]      m_vec_out_x,
    output logic signed [VEC_WIDTH-1:0]      m_vec_out_y,
    output logic signed [VEC_WIDTH-1:0]      m_vec_out_z,
    output logic                             m_saturated,
    output logic                             m_degenerate
);

    localparam int PW = MAT_WIDTH + VEC_WIDTH;
    localparam int SW = PW + 2;
    localparam int BW = SW + 2;
    localparam int QB = VEC_WIDTH + 1;
    localparam int RW = D_WIDTH + QB;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_QUAT_X = CFG_INDEX_WIDTH'(0);
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_QUAT_Y = CFG_INDEX_WIDTH'(1);
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_QUAT_Z = CFG_INDEX_WIDTH'(2);
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_QUAT_W = CFG_INDEX_WIDTH'(3);

    localparam logic signed [VEC_WIDTH-1:0] VMAX = {1'b0, {(VEC_WIDTH-1){1'b1}}};
    localparam logic signed [VEC_WIDTH-1:0] VMIN = {1'b1, {(VEC_WIDTH-1){1'b0}}};

    // configuration registers
    quat_t quat_x_reg, quat_y_reg, quat_z_reg, quat_w_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quat_x_reg <= '0;
            quat_y_reg <= '0;
            quat_z_reg <= '0;
            quat_w_reg <= QUAT_ONE;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_QUAT_X: quat_x_reg <= cfg_wdata;
                REG_QUAT_Y: quat_y_reg <= cfg_wdata;
                REG_QUAT_Z: quat_z_reg <= cfg_wdata;
                REG_QUAT_W: quat_w_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // free-running quaternion products
    logic signed [PROD_WIDTH-1:0] xx_reg, yy_reg, zz_reg, ww_reg, xy_reg;
    logic signed [PROD_WIDTH-1:0] xz_reg, xw_reg, yz_reg, yw_reg, zw_reg;
    logic signed [PROD_WIDTH-1:0] xx_next, yy_next, zz_next, ww_next, xy_next;
    logic signed [PROD_WIDTH-1:0] xz_next, xw_next, yz_next, yw_next, zw_next;

    always_comb begin
        xx_next = PROD_WIDTH'(quat_x_reg) * PROD_WIDTH'(quat_x_reg);
        yy_next = PROD_WIDTH'(quat_y_reg) * PROD_WIDTH'(quat_y_reg);
        zz_next = PROD_WIDTH'(quat_z_reg) * PROD_WIDTH'(quat_z_reg);
        ww_next = PROD_WIDTH'(quat_w_reg) * PROD_WIDTH'(quat_w_reg);
        xy_next = PROD_WIDTH'(quat_x_reg) * PROD_WIDTH'(quat_y_reg);
        xz_next = PROD_WIDTH'(quat_x_reg) * PROD_WIDTH'(quat_z_reg);
        xw_next = PROD_WIDTH'(quat_x_reg) * PROD_WIDTH'(quat_w_reg);
        yz_next = PROD_WIDTH'(quat_y_reg) * PROD_WIDTH'(quat_z_reg);
        yw_next = PROD_WIDTH'(quat_y_reg) * PROD_WIDTH'(quat_w_reg);
        zw_next = PROD_WIDTH'(quat_z_reg) * PROD_WIDTH'(quat_w_reg);
    end

    always_ff @(posedge aclk) begin
        xx_reg <= xx_next;
        yy_reg <= yy_next;
        zz_reg <= zz_next;
        ww_reg <= ww_next;
        xy_reg <= xy_next;
        xz_reg <= xz_next;
        xw_reg <= xw_next;
        yz_reg <= yz_next;
        yw_reg <= yw_next;
        zw_reg <= zw_next;
    end

    // free-running matrix scaled by the squared norm
    logic signed [MAT_WIDTH-1:0] mat_reg  [3][3];
    logic signed [MAT_WIDTH-1:0] mat_next [3][3];
    logic signed [MAT_WIDTH-1:0] norm_next;
    logic        [D_WIDTH-1:0]   d_reg, d_next;
    logic        [D_WIDTH-1:0]   norm_reg;
    logic                        degen_reg, degen_next;

    always_comb begin
        mat_next[0][0] = MAT_WIDTH'(xx_reg) - MAT_WIDTH'(yy_reg)
                       - MAT_WIDTH'(zz_reg) + MAT_WIDTH'(ww_reg);
        mat_next[0][1] = (MAT_WIDTH'(xy_reg) - MAT_WIDTH'(zw_reg)) <<< 1;
        mat_next[0][2] = (MAT_WIDTH'(xz_reg) + MAT_WIDTH'(yw_reg)) <<< 1;
        mat_next[1][0] = (MAT_WIDTH'(xy_reg) + MAT_WIDTH'(zw_reg)) <<< 1;
        mat_next[1][1] = MAT_WIDTH'(yy_reg) - MAT_WIDTH'(xx_reg)
                       - MAT_WIDTH'(zz_reg) + MAT_WIDTH'(ww_reg);
        mat_next[1][2] = (MAT_WIDTH'(yz_reg) - MAT_WIDTH'(xw_reg)) <<< 1;
        mat_next[2][0] = (MAT_WIDTH'(xz_reg) - MAT_WIDTH'(yw_reg)) <<< 1;
        mat_next[2][1] = (MAT_WIDTH'(yz_reg) + MAT_WIDTH'(xw_reg)) <<< 1;
        mat_next[2][2] = MAT_WIDTH'(zz_reg) - MAT_WIDTH'(xx_reg)
                       - MAT_WIDTH'(yy_reg) + MAT_WIDTH'(ww_reg);
        norm_next  = MAT_WIDTH'(xx_reg) + MAT_WIDTH'(yy_reg)
                   + MAT_WIDTH'(zz_reg) + MAT_WIDTH'(ww_reg);
        d_next     = {norm_next[D_WIDTH-2:0], 1'b0};
        degen_next = (norm_next == '0);
    end

    always_ff @(posedge aclk) begin
        mat_reg   <= mat_next;
        norm_reg  <= D_WIDTH'(norm_next);
        d_reg     <= d_next;
        degen_reg <= degen_next;
    end

    // item pipeline handshake
    logic       v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic       rdy1, rdy2, rdy3, rdy4, rdy5, rdy_out;
    logic       div_in_ready, div_out_valid;
    logic       m_valid_reg;

    assign rdy_out = !m_valid_reg || m_ready;
    assign rdy5    = !v5_reg || div_in_ready;
    assign rdy4    = !v4_reg || rdy5;
    assign rdy3    = !v3_reg || rdy4;
    assign rdy2    = !v2_reg || rdy3;
    assign rdy1    = !v1_reg || rdy2;
    assign s_ready = rdy1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            v5_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (rdy1)    v1_reg      <= s_valid;
            if (rdy2)    v2_reg      <= v1_reg;
            if (rdy3)    v3_reg      <= v2_reg;
            if (rdy4)    v4_reg      <= v3_reg;
            if (rdy5)    v5_reg      <= v4_reg;
            if (rdy_out) m_valid_reg <= div_out_valid;
        end
    end

    // stage 1 and 2: input word, then one delay so the matrix has settled
    logic signed [VEC_WIDTH-1:0] v1_vec_reg [3];
    logic signed [VEC_WIDTH-1:0] v2_vec_reg [3];

    always_ff @(posedge aclk) begin
        if (rdy1 && s_valid) begin
            v1_vec_reg[0] <= s_vec_in_x;
            v1_vec_reg[1] <= s_vec_in_y;
            v1_vec_reg[2] <= s_vec_in_z;
        end
        if (rdy2 && v1_reg) begin
            v2_vec_reg <= v1_vec_reg;
        end
    end

    // stage 3: matrix times vector terms
    logic signed [PW-1:0] p3_reg  [3][3];
    logic signed [PW-1:0] p3_next [3][3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                p3_next[i][j] = PW'(mat_reg[i][j]) * PW'(v2_vec_reg[j]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy3 && v2_reg) begin
            p3_reg <= p3_next;
        end
    end

    // stage 4: row sums
    logic signed [SW-1:0] s4_reg  [3];
    logic signed [SW-1:0] s4_next [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            s4_next[i] = SW'(p3_reg[i][0]) + SW'(p3_reg[i][1]) + SW'(p3_reg[i][2]);
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy4 && v3_reg) begin
            s4_reg <= s4_next;
        end
    end

    // stage 5: dividend 2s + n, biased by 2n << VEC_WIDTH so it is never negative
    logic [2:0][RW-1:0] u5_reg;
    logic [2:0][RW-1:0] u5_next;
    logic [BW-1:0]      u_wide [3];
    logic [BW-1:0]      s_ext  [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            s_ext[i]   = BW'(s4_reg[i]);
            u_wide[i]  = (s_ext[i] << 1) + BW'(norm_reg) + (BW'(d_reg) << VEC_WIDTH);
            u5_next[i] = u_wide[i][RW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy5 && v4_reg) begin
            u5_reg <= u5_next;
        end
    end

    logic [2:0][QB-1:0] div_quot;

    qvr_div #(
        .VEC_WIDTH (VEC_WIDTH)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (v5_reg),
        .in_ready  (div_in_ready),
        .in_rem    (u5_reg),
        .divisor   (d_reg),
        .out_valid (div_out_valid),
        .out_ready (rdy_out),
        .out_quot  (div_quot)
    );

    // output stage: remove bias, saturate, zero quaternion override
    logic signed [VEC_WIDTH-1:0] out_reg  [3];
    logic signed [VEC_WIDTH-1:0] out_next [3];
    logic [QB-1:0]               q_signed [3];
    logic [2:0]                  clip;
    logic                        sat_reg, sat_next;
    logic                        degen_out_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            // subtracting 2^VEC_WIDTH flips the top quotient bit
            q_signed[i] = {~div_quot[i][VEC_WIDTH], div_quot[i][VEC_WIDTH-1:0]};
            clip[i]     = q_signed[i][VEC_WIDTH] != q_signed[i][VEC_WIDTH-1];
            if (degen_reg) begin
                out_next[i] = '0;
            end else if (clip[i]) begin
                out_next[i] = q_signed[i][VEC_WIDTH] ? VMIN : VMAX;
            end else begin
                out_next[i] = q_signed[i][VEC_WIDTH-1:0];
            end
        end
        sat_next = !degen_reg && (clip != '0);
    end

    always_ff @(posedge aclk) begin
        if (rdy_out && div_out_valid) begin
            out_reg       <= out_next;
            sat_reg       <= sat_next;
            degen_out_reg <= degen_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_vec_out_x  = out_reg[0];
    assign m_vec_out_y  = out_reg[1];
    assign m_vec_out_z  = out_reg[2];
    assign m_saturated  = sat_reg;
    assign m_degenerate = degen_out_reg;

endmodule
`default_nettype wire

// ===== bench/qvr_bench_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qvr_bench_pkg
// Quaternion register indexes shared by the rotator testbench and its checker.
// ----------------------------------------------------------------------------
package qvr_bench_pkg;

    import qvr_pkg::*;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        QREG_X,
        QREG_Y,
        QREG_Z,
        QREG_W
    } qreg_e;

endpackage

// ===== bench/qvr_rotate_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qvr_rotate_checker
// Watches the quaternion writes and both vector channels, computes the
// rotated, rounded and saturated word for every accepted vector, and compares
// each returned word against the oldest one still outstanding.
// ----------------------------------------------------------------------------
module qvr_rotate_checker
    import qvr_pkg::*;
    import qvr_bench_pkg::*;
#(
    parameter int VEC_W = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [QUAT_WIDTH-1:0]       cfg_wdata,
    input  logic                        s_valid,
    input  logic                        s_ready,
    input  logic signed [VEC_W-1:0]     s_vec_in_x,
    input  logic signed [VEC_W-1:0]     s_vec_in_y,
    input  logic signed [VEC_W-1:0]     s_vec_in_z,
    input  logic                        m_valid,
    input  logic                        m_ready,
    input  logic signed [VEC_W-1:0]     m_vec_out_x,
    input  logic signed [VEC_W-1:0]     m_vec_out_y,
    input  logic signed [VEC_W-1:0]     m_vec_out_z,
    input  logic                        m_saturated,
    input  logic                        m_degenerate,
    output int                          mismatch_count,
    output int                          pending_words
);

    typedef logic signed [VEC_W-1:0] vec_t;

    typedef struct {
        vec_t x;
        vec_t y;
        vec_t z;
        logic sat;
        logic degen;
    } rot_word_t;

    localparam longint VEC_MAX = (longint'(1) <<< (VEC_W - 1)) - 1;
    localparam longint VEC_MIN = -VEC_MAX - 1;

    quat_t     quat_x_q;
    quat_t     quat_y_q;
    quat_t     quat_z_q;
    quat_t     quat_w_q;
    rot_word_t rot_q[$];
    int        err_count = 0;

    // floor division, den > 0
    function automatic longint floor_div(input longint num, input longint den);
        longint q;
        q = num / den;
        if ((num % den) != 0 && num < 0) begin
            q = q - 1;
        end
        return q;
    endfunction

    function automatic rot_word_t rotate_vec(input quat_t qx, input quat_t qy,
                                             input quat_t qz, input quat_t qw,
                                             input vec_t vx, input vec_t vy,
                                             input vec_t vz);
        longint    a, b, c, d, n, acc, r;
        longint    m[9];
        longint    v[3];
        vec_t      comp[3];
        rot_word_t rw;
        int        i;
        a = qx;
        b = qy;
        c = qz;
        d = qw;
        n = a * a + b * b + c * c + d * d;
        rw.x     = '0;
        rw.y     = '0;
        rw.z     = '0;
        rw.sat   = 1'b0;
        rw.degen = 1'b0;
        if (n == 0) begin
            rw.degen = 1'b1;
            return rw;
        end
        // rotation matrix scaled by the squared norm
        m[0] = a * a - b * b - c * c + d * d;
        m[1] = 2 * (a * b - c * d);
        m[2] = 2 * (a * c + b * d);
        m[3] = 2 * (a * b + c * d);
        m[4] = b * b - a * a - c * c + d * d;
        m[5] = 2 * (b * c - a * d);
        m[6] = 2 * (a * c - b * d);
        m[7] = 2 * (b * c + a * d);
        m[8] = c * c - a * a - b * b + d * d;
        v[0] = vx;
        v[1] = vy;
        v[2] = vz;
        for (i = 0; i < 3; i++) begin
            acc = m[3*i] * v[0] + m[3*i+1] * v[1] + m[3*i+2] * v[2];
            // nearest, ties upward: floor(acc / n + 1/2)
            r = floor_div(2 * acc + n, 2 * n);
            if (r > VEC_MAX) begin
                r      = VEC_MAX;
                rw.sat = 1'b1;
            end else if (r < VEC_MIN) begin
                r      = VEC_MIN;
                rw.sat = 1'b1;
            end
            comp[i] = vec_t'(r);
        end
        rw.x = comp[0];
        rw.y = comp[1];
        rw.z = comp[2];
        return rw;
    endfunction

    task automatic check_field(input string fname, input logic signed [63:0] want,
                               input logic signed [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, fname, want, got);
            err_count++;
        end
    endtask

    always @(posedge aclk) begin : watch
        rot_word_t want;
        if (!aresetn) begin
            quat_x_q = '0;
            quat_y_q = '0;
            quat_z_q = '0;
            quat_w_q = QUAT_ONE;
            rot_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (rot_q.size() == 0) begin
                    $display("%0t: unexpected word, expected none, got %0d %0d %0d sat %0b deg %0b",
                             $time, m_vec_out_x, m_vec_out_y, m_vec_out_z,
                             m_saturated, m_degenerate);
                    err_count++;
                end else begin
                    want = rot_q.pop_front();
                    check_field("vec_out_x", want.x, m_vec_out_x);
                    check_field("vec_out_y", want.y, m_vec_out_y);
                    check_field("vec_out_z", want.z, m_vec_out_z);
                    check_field("saturated", want.sat, m_saturated);
                    check_field("degenerate", want.degen, m_degenerate);
                end
            end
            if (s_valid && s_ready) begin
                rot_q.push_back(rotate_vec(quat_x_q, quat_y_q, quat_z_q, quat_w_q,
                                           s_vec_in_x, s_vec_in_y, s_vec_in_z));
            end
            // writes only happen with nothing in flight
            if (cfg_we) begin
                case (cfg_index)
                    QREG_X: quat_x_q = cfg_wdata;
                    QREG_Y: quat_y_q = cfg_wdata;
                    QREG_Z: quat_z_q = cfg_wdata;
                    QREG_W: quat_w_q = cfg_wdata;
                    default: ;
                endcase
            end
        end
        pending_words  <= rot_q.size();
        mismatch_count <= err_count;
    end

endmodule

// ===== bench/tb_quaternion_vector_rotate_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_quaternion_vector_rotate_top
// Drives the quaternion rotator with directed corner vectors and quaternions,
// then random batches under fresh quaternions with random gaps and stalls on
// both channels; a separate checker predicts and compares every word.
// ----------------------------------------------------------------------------
module tb_quaternion_vector_rotate_top;

    import qvr_pkg::*;
    import qvr_bench_pkg::*;

    localparam int VEC_W          = 16;
    localparam int PIPE_LATENCY   = VEC_W + 7;
    localparam int BATCH_COUNT    = 30;
    localparam int BATCH_WORDS    = 50;
    localparam int HOLD_BATCH     = 3;
    localparam int RX_HOLD_CYCLES = 200;
    localparam int DRAIN_LIMIT    = 5000;

    typedef logic signed [VEC_W-1:0] vec_t;

    localparam vec_t  VEC_HI  = vec_t'((1 << (VEC_W - 1)) - 1);
    localparam vec_t  VEC_LO  = vec_t'(1 << (VEC_W - 1));
    localparam quat_t QUAT_HI = quat_t'((1 << (QUAT_WIDTH - 1)) - 1);
    localparam quat_t QUAT_LO = quat_t'(1 << (QUAT_WIDTH - 1));

    logic                       aclk         = 1'b0;
    logic                       aresetn      = 1'b0;
    logic                       cfg_we       = 1'b0;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index    = '0;
    logic [QUAT_WIDTH-1:0]      cfg_wdata    = '0;
    logic                       s_valid      = 1'b0;
    logic                       s_ready;
    vec_t                       s_vec_in_x   = '0;
    vec_t                       s_vec_in_y   = '0;
    vec_t                       s_vec_in_z   = '0;
    logic                       m_valid;
    logic                       m_ready      = 1'b0;
    vec_t                       m_vec_out_x;
    vec_t                       m_vec_out_y;
    vec_t                       m_vec_out_z;
    logic                       m_saturated;
    logic                       m_degenerate;
    int                         mismatch_count;
    int                         pending_words;
    bit                         tx_idle      = 1'b1;
    bit                         rx_idle      = 1'b1;
    bit                         rx_hold_req  = 1'b0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    quaternion_vector_rotate_top #(
        .VEC_WIDTH (VEC_W)
    ) u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_vec_in_x   (s_vec_in_x),
        .s_vec_in_y   (s_vec_in_y),
        .s_vec_in_z   (s_vec_in_z),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_vec_out_x  (m_vec_out_x),
        .m_vec_out_y  (m_vec_out_y),
        .m_vec_out_z  (m_vec_out_z),
        .m_saturated  (m_saturated),
        .m_degenerate (m_degenerate)
    );

    qvr_rotate_checker #(
        .VEC_W (VEC_W)
    ) u_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_vec_in_x     (s_vec_in_x),
        .s_vec_in_y     (s_vec_in_y),
        .s_vec_in_z     (s_vec_in_z),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_vec_out_x    (m_vec_out_x),
        .m_vec_out_y    (m_vec_out_y),
        .m_vec_out_z    (m_vec_out_z),
        .m_saturated    (m_saturated),
        .m_degenerate   (m_degenerate),
        .mismatch_count (mismatch_count),
        .pending_words  (pending_words)
    );

    // offers one vector word and returns after an edge at which s_ready reads high
    task automatic send_word(input vec_t vx, input vec_t vy, input vec_t vz);
        int gap;
        gap = tx_idle ? $urandom_range(0, 6) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_vec_in_x <= vx;
        s_vec_in_y <= vy;
        s_vec_in_z <= vz;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_words != 0) @(posedge aclk);
        repeat (PIPE_LATENCY) @(posedge aclk);
    endtask

    // one back-to-back burst of writes, write enable held across it
    task automatic load_quat(input quat_t qx, input quat_t qy, input quat_t qz,
                             input quat_t qw);
        cfg_we    <= 1'b1;
        cfg_index <= QREG_X;
        cfg_wdata <= qx;
        @(posedge aclk);
        cfg_index <= QREG_Y;
        cfg_wdata <= qy;
        @(posedge aclk);
        cfg_index <= QREG_Z;
        cfg_wdata <= qz;
        @(posedge aclk);
        cfg_index <= QREG_W;
        cfg_wdata <= qw;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    function automatic vec_t pick_comp();
        case ($urandom_range(0, 9))
            0:       return VEC_LO;
            1:       return VEC_HI;
            2:       return '0;
            3:       return vec_t'(-1);
            4:       return vec_t'(int'($urandom_range(0, 16)) - 8);
            default: return vec_t'($urandom);
        endcase
    endfunction

    task automatic load_random_quat();
        quat_t c[4];
        int    mode;
        mode = $urandom_range(0, 9);
        foreach (c[i]) begin
            if (mode == 0) begin
                c[i] = '0;
            end else if (mode <= 2) begin
                c[i] = quat_t'(int'($urandom_range(0, 8)) - 4);
            end else if (mode <= 4) begin
                case ($urandom_range(0, 3))
                    0:       c[i] = QUAT_LO;
                    1:       c[i] = QUAT_HI;
                    2:       c[i] = '0;
                    default: c[i] = quat_t'($urandom);
                endcase
            end else begin
                c[i] = quat_t'($urandom);
            end
        end
        load_quat(c[0], c[1], c[2], c[3]);
    endtask

    // receiver side, stall drawn per word, long hold on request
    initial begin : result_sink
        int stall;
        forever begin
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                stall       = RX_HOLD_CYCLES;
            end else begin
                stall = rx_idle ? $urandom_range(0, 6) : 0;
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    initial begin : stimulus
        int b, k, drain_wait;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // identity quaternion out of reset
        send_word('0, '0, '0);
        send_word(VEC_HI, VEC_HI, VEC_HI);
        send_word(VEC_LO, VEC_LO, VEC_LO);
        send_word(VEC_HI, VEC_LO, vec_t'(1));
        send_word(vec_t'(-1), vec_t'(-1), vec_t'(-1));

        // zero quaternion
        wait_drained();
        load_quat('0, '0, '0, '0);
        send_word(VEC_HI, VEC_LO, vec_t'(5));
        send_word(vec_t'(-1), '0, vec_t'(1));

        // quarter turn about z
        wait_drained();
        load_quat('0, '0, 16'sd11585, 16'sd11585);
        send_word(vec_t'(1000), vec_t'(-3), VEC_LO);
        send_word(VEC_LO, VEC_HI, '0);

        // half turn about x, negating the minimum clips
        wait_drained();
        load_quat(16'sd16384, '0, '0, '0);
        send_word(vec_t'(100), VEC_LO, VEC_HI);
        send_word(VEC_LO, vec_t'(1), vec_t'(-1));

        wait_drained();
        load_quat(QUAT_LO, QUAT_LO, QUAT_LO, QUAT_LO);
        send_word(VEC_HI, VEC_HI, VEC_LO);
        send_word(VEC_LO, '0, VEC_HI);

        wait_drained();
        load_quat(QUAT_HI, QUAT_HI, QUAT_HI, QUAT_HI);
        send_word(VEC_LO, VEC_HI, vec_t'(7));
        send_word(VEC_HI, VEC_HI, VEC_HI);

        // norm of three, results land on thirds
        wait_drained();
        load_quat(16'sd1, 16'sd1, 16'sd1, '0);
        send_word(vec_t'(1), '0, '0);
        send_word(vec_t'(1), vec_t'(1), '0);
        send_word(VEC_HI, VEC_HI, VEC_HI);

        wait_drained();
        load_quat('0, '0, '0, QUAT_LO);
        send_word(VEC_HI, VEC_LO, vec_t'(-1));
        send_word(vec_t'(2), vec_t'(-2), vec_t'(3));

        for (b = 0; b < BATCH_COUNT; b++) begin
            wait_drained();
            load_random_quat();
            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle = ($urandom_range(0, 3) != 0);
            if (b == HOLD_BATCH) begin
                // sender runs flat out while the sink holds off
                tx_idle     = 1'b0;
                rx_hold_req = 1'b1;
            end
            for (k = 0; k < BATCH_WORDS; k++) begin
                if (k == BATCH_WORDS / 2 && $urandom_range(0, 3) == 0) begin
                    wait_drained();
                end
                send_word(pick_comp(), pick_comp(), pick_comp());
            end
        end

        s_valid <= 1'b0;
        drain_wait = 0;
        @(posedge aclk);
        while (pending_words != 0 && drain_wait < DRAIN_LIMIT) begin
            @(posedge aclk);
            drain_wait++;
        end
        repeat (PIPE_LATENCY + 8) @(posedge aclk);
        if (pending_words != 0) begin
            $display("%0t: %0d rotated words never arrived", $time, pending_words);
        end
        if (mismatch_count == 0 && pending_words == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/qvr_pkg.sv
rtl/core/qvr_div.sv
rtl/core/quaternion_vector_rotate_top.sv
bench/qvr_bench_pkg.sv
bench/qvr_rotate_checker.sv
bench/tb_quaternion_vector_rotate_top.sv
